### hdl/tea_pkg.sv
`timescale 1ns / 1ps

package tea_pkg;

   localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;
   localparam int WORD_WIDTH = 32;
   localparam int KEY_WORDS = 4;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DECRYPT_MODE = 3'd4;

   typedef struct packed {
      logic [KEY_WORDS-1:0][WORD_WIDTH-1:0] key;
      logic decrypt;
   } tea_cfg_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] hi;
      logic [WORD_WIDTH-1:0] lo;
   } tea_block_type;

   function automatic logic [WORD_WIDTH-1:0] tea_mix(
      input logic [WORD_WIDTH-1:0] x,
      input logic [WORD_WIDTH-1:0] sum,
      input logic [WORD_WIDTH-1:0] ka,
      input logic [WORD_WIDTH-1:0] kb
   );
      tea_mix = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

endpackage

### hdl/tea_block_cipher.sv
`timescale 1ns / 1ps

// TEA block cipher, one 64-bit block per word on the req channel.
// req_block_low / req_block_high carry v0 / v1; rsp_result_low / rsp_result_high
// return the enciphered or deciphered pair. A word moves when valid is high
// and stall is low.
// Keys and mode are set over the csr port (key words at 0x0..0xc, mode at 0x10).
// The user must write them only while no word is in flight (no check in the block).
// The datapath is a row of 2*ROUND_COUNT half-round cells, each one register
// stage; an accepted word passes through every cell register in turn to
// rsp_valid, and a new word is taken every cycle while req_stall is low.
// When rsp_stall is high the row keeps moving until words pile up behind the
// last cell; empty cells still fill, so req_stall rises only once every cell
// holds a word. The last cell is the output register and holds its word.
// Reset clears the cell valid bits, the key words and the mode (encrypt).
module tea_block_cipher #(
   parameter int ROUND_COUNT = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [31:0] req_block_low,
   input  logic [31:0] req_block_high,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [31:0] rsp_result_low,
   output logic [31:0] rsp_result_high,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [tea_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tea_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [tea_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic csr_pready
);
   import tea_pkg::*;

   localparam int CELLS = 2 * ROUND_COUNT;

   tea_cfg_type cfg;
   logic [CELLS:0] valid_chain;
   logic [CELLS:0] ready_chain;
   tea_block_type data_chain [CELLS+1];

   tea_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   assign valid_chain[0] = req_valid;
   assign data_chain[0].lo = req_block_low;
   assign data_chain[0].hi = req_block_high;
   assign req_stall = !ready_chain[0];
   assign ready_chain[CELLS] = !rsp_stall;

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      tea_cell #(
         .ROUND_COUNT(ROUND_COUNT),
         .STAGE(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .cfg(cfg),
         .in_valid(valid_chain[i]),
         .in_data(data_chain[i]),
         .in_ready(ready_chain[i]),
         .out_valid(valid_chain[i+1]),
         .out_data(data_chain[i+1]),
         .out_ready(ready_chain[i+1])
      );
   end

   assign rsp_valid = valid_chain[CELLS];
   assign rsp_result_low = data_chain[CELLS].lo;
   assign rsp_result_high = data_chain[CELLS].hi;

`ifndef SYNTH
   // input side only backs up when every cell is full and the output is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_chain[CELLS:1]) && rsp_stall)
      else $error("req_stall with an empty cell");

   // an accepted word lands in the first cell
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_chain[1])
      else $error("accepted word lost at first cell");

   // a held result keeps its place at the end of the row
   a_held_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_low) &&
         $stable(rsp_result_high))
      else $error("result dropped while stalled");

   // mode write reaches the cells on the next cycle
   a_mode_write: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite &&
      csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_DECRYPT_MODE
      |=> cfg.decrypt == $past(csr_pwdata[0]))
      else $error("decrypt mode not updated");
`endif

endmodule

### hdl/tea_csr.sv
`timescale 1ns / 1ps

module tea_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [tea_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tea_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [tea_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic csr_pready,
   output tea_pkg::tea_cfg_type cfg
);
   import tea_pkg::*;

   logic [KEY_WORDS-1:0][WORD_WIDTH-1:0] key_ff, key_in;
   logic decrypt_ff, decrypt_in;
   logic wr_en;
   logic [CSR_INDEX_WIDTH-1:0] idx;

   assign idx = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      key_in = key_ff;
      decrypt_in = decrypt_ff;
      if (wr_en) begin
         case (idx)
            REG_KEY_WORD_0: key_in[0] = csr_pwdata;
            REG_KEY_WORD_1: key_in[1] = csr_pwdata;
            REG_KEY_WORD_2: key_in[2] = csr_pwdata;
            REG_KEY_WORD_3: key_in[3] = csr_pwdata;
            REG_DECRYPT_MODE: decrypt_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         decrypt_ff <= 1'b0;
      end else begin
         key_ff <= key_in;
         decrypt_ff <= decrypt_in;
      end
   end

   always_comb begin
      case (idx)
         REG_KEY_WORD_0: csr_prdata = key_ff[0];
         REG_KEY_WORD_1: csr_prdata = key_ff[1];
         REG_KEY_WORD_2: csr_prdata = key_ff[2];
         REG_KEY_WORD_3: csr_prdata = key_ff[3];
         REG_DECRYPT_MODE: csr_prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, decrypt_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign cfg.key = key_ff;
   assign cfg.decrypt = decrypt_ff;

endmodule

### hdl/tea_cell.sv
`timescale 1ns / 1ps

module tea_cell #(
   parameter int ROUND_COUNT = 32,
   parameter int STAGE = 0
) (
   input  logic clock,
   input  logic reset,
   input  tea_pkg::tea_cfg_type cfg,
   input  logic in_valid,
   input  tea_pkg::tea_block_type in_data,
   output logic in_ready,
   output logic out_valid,
   output tea_pkg::tea_block_type out_data,
   input  logic out_ready
);
   import tea_pkg::*;

   localparam int ROUND = STAGE / 2;
   localparam bit SECOND_HALF = (STAGE % 2) == 1;
   localparam logic [63:0] ENC_SUM_FULL = 64'(TEA_DELTA) * 64'(ROUND + 1);
   localparam logic [63:0] DEC_SUM_FULL = 64'(TEA_DELTA) * 64'(ROUND_COUNT - ROUND);
   localparam logic [WORD_WIDTH-1:0] ENC_SUM = ENC_SUM_FULL[WORD_WIDTH-1:0];
   localparam logic [WORD_WIDTH-1:0] DEC_SUM = DEC_SUM_FULL[WORD_WIDTH-1:0];

   logic valid_ff, valid_in;
   tea_block_type data_ff, data_in;
   logic upd_lo;
   logic [WORD_WIDTH-1:0] x, ka, kb, sum, mix, target, updated;

   // encrypt touches lo first, decrypt touches hi first
   assign upd_lo = (SECOND_HALF == cfg.decrypt);

   always_comb begin
      x = upd_lo ? in_data.hi : in_data.lo;
      ka = upd_lo ? cfg.key[0] : cfg.key[2];
      kb = upd_lo ? cfg.key[1] : cfg.key[3];
      sum = cfg.decrypt ? DEC_SUM : ENC_SUM;
      mix = tea_mix(x, sum, ka, kb);
      target = upd_lo ? in_data.lo : in_data.hi;
      updated = cfg.decrypt ? (target - mix) : (target + mix);
      data_in.lo = upd_lo ? updated : in_data.lo;
      data_in.hi = upd_lo ? in_data.hi : updated;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule
